[src/smmd3_pkg.sv]
// Package for the square matrix multiplier with 3x3 determinant.
// Holds the sizes, command and state codes and control structs that all modules share.
// No dependencies.
`default_nettype none

package smmd3_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W     = 32;
    localparam int POS_W      = 3;
    localparam int CMD_W      = 2;
    localparam int DIM_W      = 4;

    // Largest matrix held, and sizes derived from it.
    localparam int MAX_DIM    = 8;
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int IDX_W      = $clog2(MAX_DIM * MAX_DIM);

    // Determinant support: a 3x3 corner of A.
    localparam int DET_DIM    = 3;
    localparam int DET_N      = DET_DIM * DET_DIM;
    localparam int DET_SLOT_W = $clog2(DET_N);

    // Configuration port.
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_DIMENSION = 0;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DET_RD,
        S_DET_GO,
        S_DET_RUN,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } state_t;

    // Write port of the matrix store.
    typedef struct packed {
        logic              we_a;
        logic              we_b;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } store_wr_t;

    // One multiply-accumulate step issued to the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // Capture and start control of the determinant unit.
    typedef struct packed {
        logic                  cap;
        logic [DET_SLOT_W-1:0] slot;
        logic                  start;
    } det_ctl_t;

    // Row-major index of a matrix entry.
    function automatic logic [IDX_W-1:0] mat_idx(input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] c);
        return IDX_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

endpackage

`default_nettype wire

[src/square_matrix_multiply_det3.sv]
// Top level of the square matrix multiplier with 3x3 determinant.
// Instantiates smmd3_store, smmd3_mac and smmd3_det; uses smmd3_pkg.
//
// Usage.
// Input beats on s_* carry a command in s_tuser: load an element of A, load an
// element of B, or compute. A load beat is written to the store in the cycle
// it is accepted and gives no output. A compute beat emits dimension squared
// beats on m_*, row-major, with m_tlast on the final element; m_tuser is set
// when the dimension is three and the determinant field is then meaningful.
// Throughput: loads stream at one beat a cycle while the block is idle.
// Compute time for dimension d is set by the single read port of each
// memory and the single multiply-accumulate pipeline: d reads per element,
// plus the read and MAC latency, plus the hand-over of the element. At
// dimension three a determinant pass runs ahead of the products (nine
// corner reads and nine steps of the shared determinant multiplier).
// s_tready is high only between runs.
// A stalled receiver holds the output register; the run waits and resumes
// when the beat is taken, and the next input beat can still be accepted while
// the final element of a run waits. Reset sets the dimension to one and
// leaves the matrix contents undefined; there is no clearing pass.
// The dimension register sits at byte address 0 of the APB port.
`default_nettype none

module square_matrix_multiply_det3 (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata: row [2:0], col [5:3], value [37:6], zero [39:38].
    input  wire logic [39:0]                         s_tdata,
    // s_tuser: cmd [1:0].
    input  wire logic [smmd3_pkg::CMD_W-1:0]         s_tuser,
    // Output stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata: out_row [2:0], out_col [5:3], product [37:6],
    // determinant [69:38], zero [71:70].
    output logic      [71:0]                         m_tdata,
    // m_tuser: det_valid [0].
    output logic      [0:0]                          m_tuser,
    output logic                                     m_tlast,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [smmd3_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [smmd3_pkg::PDATA_W-1:0]       pwdata,
    output logic      [smmd3_pkg::PDATA_W-1:0]       prdata,
    output logic                                     pready
);
    import smmd3_pkg::*;

    localparam logic [CNT_W-1:0] DET_LAST = CNT_W'(DET_DIM - 1);

    // Unpacked input fields.
    logic [POS_W-1:0]  in_row;
    logic [POS_W-1:0]  in_col;
    logic [DATA_W-1:0] in_value;
    logic              in_accept;

    // Control state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [DIM_W-1:0]  deff_reg, deff_next;
    logic [DIM_W-1:0]  dim_reg;
    logic [DIM_W-1:0]  dim_eff;
    logic [CNT_W-1:0]  dlast;
    logic              has_det;
    logic              det_cap_reg, det_cap_next;
    logic [DET_SLOT_W-1:0] det_slot_reg, det_slot_next;
    logic              det_start;

    // Output register.
    logic              m_tvalid_reg, m_tvalid_next;
    logic              out_load;
    logic [POS_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  out_col_reg;
    logic [DATA_W-1:0] out_prod_reg;
    logic [DATA_W-1:0] out_det_reg;
    logic              out_dv_reg;
    logic              out_last_reg;

    // Submodule connections.
    store_wr_t         wr;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;
    mac_ctl_t          mac_ctl;
    logic [DATA_W-1:0] mac_acc;
    logic              mac_done;
    det_ctl_t          det_ctl;
    logic [DATA_W-1:0] det_value;
    logic              det_busy;
    logic              cfg_we;

    assign in_row    = s_tdata[2:0];
    assign in_col    = s_tdata[5:3];
    assign in_value  = s_tdata[37:6];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Configuration register: decoded on the word address.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite &&
                    (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_DIMENSION));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            dim_reg <= pwdata[DIM_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_DIMENSION))
        begin
            prdata = PDATA_W'(dim_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // Effective dimension: zero counts as one, large values saturate.
    always_comb
    begin
        if (dim_reg == '0)
        begin
            dim_eff = DIM_W'(1);
        end
        else if (int'(dim_reg) > MAX_DIM)
        begin
            dim_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = dim_reg;
        end
    end

    assign dlast   = CNT_W'(deff_reg - 1'b1);
    assign has_det = (deff_reg == DIM_W'(DET_DIM));

    // Sequencer. Loads are taken only in idle, so a store write never meets
    // a read of a run in progress.
    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        deff_next     = deff_reg;
        det_cap_next  = 1'b0;
        det_slot_next = det_slot_reg;
        det_start     = 1'b0;
        out_load      = 1'b0;
        mac_ctl       = '0;
        wr.we_a       = 1'b0;
        wr.we_b       = 1'b0;
        wr.addr       = mat_idx(in_row, in_col);
        wr.data       = in_value;
        raddr_a       = mat_idx(POS_W'(i_reg), POS_W'(k_reg));
        raddr_b       = mat_idx(POS_W'(k_reg), POS_W'(j_reg));

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (cmd_t'(s_tuser))
                        CMD_LOAD_A:
                        begin
                            wr.we_a = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
                        end
                        CMD_LOAD_B:
                        begin
                            wr.we_b = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
                        end
                        CMD_COMPUTE:
                        begin
                            deff_next = dim_eff;
                            i_next    = '0;
                            j_next    = '0;
                            k_next    = '0;
                            if (dim_eff == DIM_W'(DET_DIM))
                            begin
                                state_next = S_DET_RD;
                            end
                            else
                            begin
                                state_next = S_ISSUE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Read the 3x3 corner of A, i as row and k as column.
            S_DET_RD:
            begin
                det_cap_next  = 1'b1;
                det_slot_next = DET_SLOT_W'(int'(i_reg) * DET_DIM + int'(k_reg));
                if (k_reg == DET_LAST)
                begin
                    k_next = '0;
                    if (i_reg == DET_LAST)
                    begin
                        i_next     = '0;
                        state_next = S_DET_GO;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            // The last corner entry is captured in this cycle.
            S_DET_GO:
            begin
                det_start  = 1'b1;
                state_next = S_DET_RUN;
            end

            S_DET_RUN:
            begin
                if (!det_busy)
                begin
                    state_next = S_ISSUE;
                end
            end

            // One term of element (i, j) per cycle.
            S_ISSUE:
            begin
                mac_ctl.valid = 1'b1;
                mac_ctl.first = (k_reg == '0);
                mac_ctl.last  = (k_reg == dlast);
                if (k_reg == dlast)
                begin
                    k_next     = '0;
                    state_next = S_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            S_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = S_EMIT;
                end
            end

            // Hand the element to the output register once it is free.
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (j_reg == dlast)
                    begin
                        j_next = '0;
                        if (i_reg == dlast)
                        begin
                            i_next     = '0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = S_ISSUE;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on a load, cleared when the beat is taken.
    always_comb
    begin
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            deff_reg     <= DIM_RESET;
            det_cap_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            deff_reg     <= deff_next;
            det_cap_reg  <= det_cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        det_slot_reg <= det_slot_next;
        if (out_load)
        begin
            out_row_reg  <= POS_W'(i_reg);
            out_col_reg  <= POS_W'(j_reg);
            out_prod_reg <= mac_acc;
            out_det_reg  <= has_det ? det_value : '0;
            out_dv_reg   <= has_det;
            out_last_reg <= (i_reg == dlast) && (j_reg == dlast);
        end
    end

    assign det_ctl.cap   = det_cap_reg;
    assign det_ctl.slot  = det_slot_reg;
    assign det_ctl.start = det_start;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_det_reg, out_prod_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_dv_reg;
    assign m_tlast  = out_last_reg;

    smmd3_store u_store (
        .clk     (clk),
        .wr      (wr),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    smmd3_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    smmd3_det u_det (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (det_ctl),
        .rdata_a (rdata_a),
        .det     (det_value),
        .busy    (det_busy)
    );

    // The product walk never overlaps the determinant pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctl.valid |-> !det_busy)
        else $error("product issued while determinant unit busy");

    // Corner entries are only captured while the determinant unit is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        det_ctl.cap |-> !det_busy)
        else $error("determinant capture while unit busy");

    // A finished sum arrives only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == S_WAIT))
        else $error("MAC result outside the wait state");

    // No store write while a read of the run is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr.we_a || wr.we_b) |-> !(mac_ctl.valid || det_cap_next))
        else $error("store write during a read pass");

endmodule

`default_nettype wire

[src/smmd3_store.sv]
// Matrix store: two synchronous memories holding A and B, row-major.
// One write port shared by both, one registered read port each. Uses smmd3_pkg.
`default_nettype none

module smmd3_store (
    input  wire logic                       clk,
    input  wire smmd3_pkg::store_wr_t       wr,
    input  wire logic [smmd3_pkg::IDX_W-1:0]  raddr_a,
    input  wire logic [smmd3_pkg::IDX_W-1:0]  raddr_b,
    output logic      [smmd3_pkg::DATA_W-1:0] rdata_a,
    output logic      [smmd3_pkg::DATA_W-1:0] rdata_b
);
    import smmd3_pkg::*;

    logic [DATA_W-1:0] mem_a [MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0] mem_b [MAX_DIM*MAX_DIM];

    // Matrix A: write, then registered read.
    always_ff @(posedge clk)
    begin
        if (wr.we_a)
        begin
            mem_a[wr.addr] <= wr.data;
        end
        rdata_a <= mem_a[raddr_a];
    end

    // Matrix B: write, then registered read.
    always_ff @(posedge clk)
    begin
        if (wr.we_b)
        begin
            mem_b[wr.addr] <= wr.data;
        end
        rdata_b <= mem_b[raddr_b];
    end

endmodule

`default_nettype wire

[src/smmd3_mac.sv]
// Multiply-accumulate pipeline for one product element.
// Follows the store's read latency, registers the product, then accumulates. Uses smmd3_pkg.
`default_nettype none

module smmd3_mac (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire smmd3_pkg::mac_ctl_t          ctl,
    input  wire logic [smmd3_pkg::DATA_W-1:0] rdata_a,
    input  wire logic [smmd3_pkg::DATA_W-1:0] rdata_b,
    output logic      [smmd3_pkg::DATA_W-1:0] acc,
    output logic                              done
);
    import smmd3_pkg::*;

    mac_ctl_t          s1_reg;
    mac_ctl_t          s2_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic              done_reg;

    // Stage tags follow the read data and the product down the pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= ctl;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg.valid && s2_reg.last;
        end
    end

    // The first term of an element restarts the sum; the sum wraps at 32 bits.
    always_comb
    begin
        acc_next = s2_reg.first ? prod_reg : acc_reg + prod_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            prod_reg <= rdata_a * rdata_b;
        end
        if (s2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[src/smmd3_det.sv]
// Determinant unit: cofactor expansion of a captured 3x3 corner of A.
// One shared multiplier, nine products, each a multiply phase and a fold phase. Uses smmd3_pkg.
`default_nettype none

module smmd3_det (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire smmd3_pkg::det_ctl_t          ctl,
    input  wire logic [smmd3_pkg::DATA_W-1:0] rdata_a,
    output logic      [smmd3_pkg::DATA_W-1:0] det,
    output logic                              busy
);
    import smmd3_pkg::*;

    typedef enum logic [2:0] {
        OP_MINOR_SET,
        OP_MINOR_SUB,
        OP_DET_SET,
        OP_DET_SUB,
        OP_DET_ADD
    } det_op_t;

    localparam logic [DET_SLOT_W-1:0] LAST_STEP = DET_SLOT_W'(DET_N - 1);

    logic [DATA_W-1:0]     a_reg [DET_N];
    logic [DATA_W-1:0]     prod_reg;
    logic [DATA_W-1:0]     minor_reg;
    logic [DATA_W-1:0]     det_reg;
    logic [DET_SLOT_W-1:0] step_reg;
    logic                  phase_reg;
    logic                  busy_reg;
    logic [DATA_W-1:0]     op_x;
    logic [DATA_W-1:0]     op_y;
    det_op_t               op;

    // Capture the corner entries as they arrive from the store.
    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            a_reg[ctl.slot] <= rdata_a;
        end
    end

    // Operand schedule: two products form a minor, the third weighs it.
    // Slot numbering is row times three plus column.
    always_comb
    begin
        op_x = a_reg[4];
        op_y = a_reg[8];
        op   = OP_MINOR_SET;
        case (step_reg)
            4'd0:
            begin
                op_x = a_reg[4]; op_y = a_reg[8]; op = OP_MINOR_SET;
            end
            4'd1:
            begin
                op_x = a_reg[5]; op_y = a_reg[7]; op = OP_MINOR_SUB;
            end
            4'd2:
            begin
                op_x = a_reg[0]; op_y = minor_reg; op = OP_DET_SET;
            end
            4'd3:
            begin
                op_x = a_reg[3]; op_y = a_reg[8]; op = OP_MINOR_SET;
            end
            4'd4:
            begin
                op_x = a_reg[5]; op_y = a_reg[6]; op = OP_MINOR_SUB;
            end
            4'd5:
            begin
                op_x = a_reg[1]; op_y = minor_reg; op = OP_DET_SUB;
            end
            4'd6:
            begin
                op_x = a_reg[3]; op_y = a_reg[7]; op = OP_MINOR_SET;
            end
            4'd7:
            begin
                op_x = a_reg[4]; op_y = a_reg[6]; op = OP_MINOR_SUB;
            end
            4'd8:
            begin
                op_x = a_reg[2]; op_y = minor_reg; op = OP_DET_ADD;
            end
            default:
            begin
                op_x = a_reg[4]; op_y = a_reg[8]; op = OP_MINOR_SET;
            end
        endcase
    end

    // Sequencer: multiply in phase zero, fold the product in phase one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            step_reg  <= '0;
        end
        else if (busy_reg)
        begin
            phase_reg <= !phase_reg;
            if (phase_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // Datapath: products and sums wrap at 32 bits.
    always_ff @(posedge clk)
    begin
        if (busy_reg && !phase_reg)
        begin
            prod_reg <= op_x * op_y;
        end
        if (busy_reg && phase_reg)
        begin
            case (op)
                OP_MINOR_SET: minor_reg <= prod_reg;
                OP_MINOR_SUB: minor_reg <= minor_reg - prod_reg;
                OP_DET_SET:   det_reg   <= prod_reg;
                OP_DET_SUB:   det_reg   <= det_reg - prod_reg;
                OP_DET_ADD:   det_reg   <= det_reg + prod_reg;
                default:      det_reg   <= det_reg;
            endcase
        end
    end

    assign det  = det_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

[tb/sv/smmd3_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the square matrix multiplier testbench: mirrors both matrix
// stores and the dimension register, and predicts every product beat.
// Depends on smmd3_pkg.
package smmd3_tb_pkg;
    import smmd3_pkg::*;

    // The one command code that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    // One predicted product beat.
    typedef struct {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [DATA_W-1:0] product;
        logic [DATA_W-1:0] determinant;
        logic              det_valid;
        logic              last;
    } product_elem_t;

    class product_scoreboard;
        logic [DATA_W-1:0] a_mem [MAX_DIM*MAX_DIM];
        logic [DATA_W-1:0] b_mem [MAX_DIM*MAX_DIM];
        logic [DIM_W-1:0]  dim_reg;
        product_elem_t     expected_elems [$];
        int                errors;

        function new();
            foreach (a_mem[i])
            begin
                a_mem[i] = '0;
                b_mem[i] = '0;
            end
            dim_reg = DIM_RESET;
            errors  = 0;
        endfunction

        function void set_dimension(input logic [DIM_W-1:0] value);
            dim_reg = value;
        endfunction

        function int pending();
            return expected_elems.size();
        endfunction

        // Zero counts as one, anything past the store size saturates.
        function int dim_in_use();
            if (dim_reg == '0)
                return 1;
            if (int'(dim_reg) > MAX_DIM)
                return MAX_DIM;
            return int'(dim_reg);
        endfunction

        function logic [DATA_W-1:0] a_at(input int r, input int c);
            return a_mem[r * MAX_DIM + c];
        endfunction

        // Cofactor expansion along the top row, wrapping at 32 bits throughout.
        function logic [DATA_W-1:0] corner_det();
            logic [DATA_W-1:0] m1;
            logic [DATA_W-1:0] m2;
            logic [DATA_W-1:0] m3;
            logic [DATA_W-1:0] det;
            m1  = a_at(1, 1) * a_at(2, 2) - a_at(1, 2) * a_at(2, 1);
            m2  = a_at(1, 0) * a_at(2, 2) - a_at(1, 2) * a_at(2, 0);
            m3  = a_at(1, 0) * a_at(2, 1) - a_at(1, 1) * a_at(2, 0);
            det = a_at(0, 0) * m1 - a_at(0, 1) * m2 + a_at(0, 2) * m3;
            return det;
        endfunction

        // Queue one beat per element of C = A * B, row-major.
        function void predict_product();
            int                d;
            logic [DATA_W-1:0] det;
            logic [DATA_W-1:0] acc;
            product_elem_t     elem;
            d   = dim_in_use();
            det = (d == DET_DIM) ? corner_det() : '0;
            for (int i = 0; i < d; i++)
            begin
                for (int j = 0; j < d; j++)
                begin
                    acc = '0;
                    for (int k = 0; k < d; k++)
                        acc = acc + a_mem[i * MAX_DIM + k] * b_mem[k * MAX_DIM + j];
                    elem.row         = POS_W'(i);
                    elem.col         = POS_W'(j);
                    elem.product     = acc;
                    elem.determinant = det;
                    elem.det_valid   = (d == DET_DIM);
                    elem.last        = (i == d - 1) && (j == d - 1);
                    expected_elems.insert(expected_elems.size(), elem);
                end
            end
        endfunction

        // Called for every accepted input beat.
        function void note_beat(input logic [CMD_W-1:0]  cmd,
                                input logic [POS_W-1:0]  row,
                                input logic [POS_W-1:0]  col,
                                input logic [DATA_W-1:0] value);
            case (cmd)
                CMD_LOAD_A:  a_mem[int'(row) * MAX_DIM + int'(col)] = value;
                CMD_LOAD_B:  b_mem[int'(row) * MAX_DIM + int'(col)] = value;
                CMD_COMPUTE: predict_product();
                default:     ;
            endcase
        endfunction

        function void check_field(input string name, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // Called for every accepted product beat.
        function void check_elem(input logic [POS_W-1:0]  row,
                                 input logic [POS_W-1:0]  col,
                                 input logic [DATA_W-1:0] product,
                                 input logic [DATA_W-1:0] determinant,
                                 input logic              det_valid,
                                 input logic              last);
            product_elem_t want;
            if (expected_elems.size() == 0)
            begin
                $error("product beat with nothing expected: row %0d col %0d", row, col);
                errors++;
                return;
            end
            want = expected_elems.pop_front();
            check_field("out_row", DATA_W'(want.row), DATA_W'(row));
            check_field("out_col", DATA_W'(want.col), DATA_W'(col));
            check_field("product", want.product, product);
            check_field("determinant", want.determinant, determinant);
            check_field("det_valid", DATA_W'(want.det_valid), DATA_W'(det_valid));
            check_field("last", DATA_W'(want.last), DATA_W'(last));
        endfunction
    endclass

endpackage

[tb/sv/square_matrix_multiply_det3_tb.sv]
`timescale 1ns / 100ps
// Top of the testbench for square_matrix_multiply_det3: drives load and compute
// beats and the dimension register, and checks every product beat.
// Depends on smmd3_pkg, smmd3_tb_pkg and the block's RTL.
module square_matrix_multiply_det3_tb;
    import smmd3_pkg::*;
    import smmd3_tb_pkg::*;

    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 16;
    localparam int ITEM_TARGET  = 320;
    localparam int PHASE_DIMS [10] = '{3, 2, 15, 1, 3, 0, 4, 9, 8, 3};

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // s_tdata: row [2:0], col [5:3], value [37:6], zero [39:38].
    logic [39:0]         s_tdata  = '0;
    // s_tuser: cmd [1:0].
    logic [CMD_W-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // m_tdata: out_row [2:0], out_col [5:3], product [37:6], determinant [69:38].
    logic [71:0]         m_tdata;
    // m_tuser: det_valid [0].
    logic [0:0]          m_tuser;
    logic                m_tlast;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    product_scoreboard   sb;
    bit                  tx_idle_en    = 1'b1;
    bit                  rx_idle_en    = 1'b1;
    bit                  long_hold_req = 1'b0;
    bit [63:0]           a_written     = '0;
    bit [63:0]           b_written     = '0;
    int                  items_sent    = 0;
    int                  stall_cycles  = 0;

    square_matrix_multiply_det3 u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Sample both streams at the rising edge and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_elem(m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tdata[69:38],
                              m_tuser[0], m_tlast);
            if (s_tvalid && s_tready)
                sb.note_beat(s_tuser, s_tdata[2:0], s_tdata[5:3], s_tdata[37:6]);
        end
    end

    // Give up when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Receiver: random back-pressure bursts, plus one long hold on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Element values biased towards the corners of the signed range.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(0, 32)) - 32'd16;
            default: return $urandom();
        endcase
    endfunction

    function automatic int dim_in_use(input int value);
        if (value == 0)
            return 1;
        return (value > MAX_DIM) ? MAX_DIM : value;
    endfunction

    // Offer one input beat and hold it until it is taken.
    task automatic send_beat(input logic [CMD_W-1:0]  cmd,
                             input logic [POS_W-1:0]  row,
                             input logic [POS_W-1:0]  col,
                             input logic [DATA_W-1:0] value);
        int gap;
        if (tx_idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, value, col, row};
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_LOAD_A)
            a_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
        if (cmd == CMD_LOAD_B)
            b_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
        if (cmd != CMD_RESERVED)
            items_sent++;
    endtask

    // Stop offering beats and wait until every expected product has come.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic program_dimension(input int value);
        wait_idle();
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(4 * REG_DIMENSION);
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_dimension(DIM_W'(value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Load every entry a compute at dimension d will read but that was never written.
    task automatic fill_missing(input int d);
        for (int i = 0; i < d; i++)
        begin
            for (int k = 0; k < d; k++)
            begin
                if (!a_written[i * MAX_DIM + k])
                    send_beat(CMD_LOAD_A, POS_W'(i), POS_W'(k), pick_value());
                if (!b_written[i * MAX_DIM + k])
                    send_beat(CMD_LOAD_B, POS_W'(i), POS_W'(k), pick_value());
            end
        end
    endtask

    // A few loads, mostly inside the active dimension, with the odd reserved command.
    task automatic random_loads(input int d, input int count);
        int r;
        int c;
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(CMD_RESERVED, POS_W'($urandom_range(0, 7)),
                          POS_W'($urandom_range(0, 7)), pick_value());
            if ($urandom_range(0, 4) != 0)
            begin
                r = $urandom_range(0, d - 1);
                c = $urandom_range(0, d - 1);
            end
            else
            begin
                r = $urandom_range(0, 7);
                c = $urandom_range(0, 7);
            end
            send_beat($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                      POS_W'(r), POS_W'(c), pick_value());
        end
    endtask

    initial
    begin
        int  phase;
        int  dim_val;
        int  d;
        bit  tail;
        bit  long_hold_done;
        sb = new();
        phase          = 0;
        long_hold_done = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset dimension of one: wrapping products,
        // the reserved command, loads beyond the dimension, then dimension zero.
        send_beat(CMD_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
        send_beat(CMD_LOAD_B, 3'd0, 3'd0, 32'hFFFF_FFFF);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
        send_beat(CMD_RESERVED, 3'd0, 3'd0, 32'h1234_5678);
        send_beat(CMD_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_beat(CMD_LOAD_A, 3'd7, 3'd7, 32'h7FFF_FFFF);
        send_beat(CMD_LOAD_B, 3'd7, 3'd7, 32'h8000_0000);
        send_beat(CMD_LOAD_A, 3'd0, 3'd7, 32'hFFFF_FFFF);
        send_beat(CMD_LOAD_B, 3'd7, 3'd0, 32'h0000_0001);
        send_beat(CMD_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_beat(CMD_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_beat(CMD_COMPUTE, 3'd5, 3'd2, 32'hA5A5_A5A5);
        send_beat(CMD_COMPUTE, 3'd2, 3'd5, 32'h5A5A_5A5A);
        program_dimension(0);
        send_beat(CMD_LOAD_B, 3'd0, 3'd0, 32'h0000_0000);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);

        // Random phases, each at its own dimension, drained before the next write.
        while (items_sent < ITEM_TARGET)
        begin
            if (phase < $size(PHASE_DIMS))
                dim_val = PHASE_DIMS[phase];
            else if ($urandom_range(0, 3) == 0)
                dim_val = $urandom_range(0, 15);
            else
                dim_val = $urandom_range(1, 4);
            tail = (items_sent >= ITEM_TARGET - 60);
            program_dimension(dim_val);
            tx_idle_en = !tail && ($urandom_range(0, 3) != 0);
            rx_idle_en = !tail && ($urandom_range(0, 3) != 0);
            d = dim_in_use(dim_val);
            repeat ($urandom_range(1, 3))
            begin
                random_loads(d, $urandom_range(1, 8));
                fill_missing(d);
                if (!long_hold_done && d >= 2)
                begin
                    // Hold the output off so the block stalls its input while
                    // further loads keep being offered.
                    long_hold_req = 1'b1;
                    send_beat(CMD_COMPUTE, 3'd0, 3'd0, pick_value());
                    random_loads(d, 6);
                    long_hold_done = 1'b1;
                end
                else
                    send_beat(CMD_COMPUTE, POS_W'($urandom_range(0, 7)),
                              POS_W'($urandom_range(0, 7)), pick_value());
                if ($urandom_range(0, 3) == 0)
                    send_beat(CMD_COMPUTE, 3'd0, 3'd0, pick_value());
            end
            phase++;
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
